@@ rtl/bbt_pkg.sv @@
`timescale 1ns / 1ps

package bbt_pkg;

    // Balanced ternary digits per word. The bias follows from it.
    localparam int TRIT_COUNT = 10;

    function automatic int calc_bias(input int trits);
        int p;
        p = 1;
        for (int i = 0; i < trits; i++) begin
            p = p * 3;
        end
        return (p - 1) / 2;
    endfunction

    localparam int BIAS = calc_bias(TRIT_COUNT);

    localparam int WORD_W = 16;
    localparam int CMD_W  = 3;

    localparam logic [WORD_W-1:0] ERR_CODE    = 16'hFFFF;
    localparam logic [WORD_W-1:0] BIAS_W      = WORD_W'(BIAS);
    localparam logic [WORD_W-1:0] TWO_BIAS_W  = WORD_W'(2 * BIAS);
    localparam logic signed [33:0] BIAS_S     = 34'(BIAS);

    // Restoring divider: two quotient bits per pipeline stage.
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = WORD_W / DIV_BITS_PER_STAGE;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MOD = 3'd4,
        CMD_NEG = 3'd5,
        CMD_ABS = 3'd6
    } t_cmd;

    // Decoded operands and the cheap results, after the first stage.
    typedef struct packed {
        t_cmd                cmd;
        logic                a_err;
        logic                b_err;
        logic signed [16:0]  va;
        logic signed [16:0]  vb;
        logic signed [17:0]  sum;
        logic signed [17:0]  diff;
        logic signed [33:0]  prod;
        logic [WORD_W-1:0]   neg_code;
        logic [WORD_W-1:0]   abs_code;
    } t_dec_item;

    // Item as it travels through the divider stages. For items that do not
    // divide, code already holds the final result.
    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic              is_div;
        logic              is_mod;
        logic              neg_q;
        logic              neg_r;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] den;
    } t_div_item;

    // Range check and biased encoding of an exact balanced value.
    function automatic logic [WORD_W-1:0] enc_checked(input logic signed [33:0] v);
        logic [WORD_W-1:0] r;
        if (v < -BIAS_S || v > BIAS_S) begin
            r = ERR_CODE;
        end else begin
            r = WORD_W'(v + BIAS_S);
        end
        return r;
    endfunction

endpackage

@@ rtl/bbt_decode.sv @@
`timescale 1ns / 1ps

module bbt_decode
    import bbt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic              o_valid,
    input  logic              i_ready,
    output t_dec_item         o_item
);

    logic              r_valid;
    t_dec_item         r_item;
    t_dec_item         n_item;
    logic signed [16:0] va;
    logic signed [16:0] vb;

    assign va = $signed({1'b0, i_operand_a}) - $signed({1'b0, BIAS_W});
    assign vb = $signed({1'b0, i_operand_b}) - $signed({1'b0, BIAS_W});

    always_comb begin
        n_item.cmd      = t_cmd'(i_cmd);
        n_item.a_err    = (i_operand_a == ERR_CODE);
        n_item.b_err    = (i_operand_b == ERR_CODE);
        n_item.va       = va;
        n_item.vb       = vb;
        n_item.sum      = 18'(va) + 18'(vb);
        n_item.diff     = 18'(va) - 18'(vb);
        n_item.prod     = 34'(va) * 34'(vb);
        n_item.neg_code = TWO_BIAS_W - i_operand_a;
        // For a negative value, bias - v equals 2*bias - stored.
        n_item.abs_code = va[16] ? (TWO_BIAS_W - i_operand_a) : i_operand_a;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_item <= n_item;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/bbt_select.sv @@
`timescale 1ns / 1ps

module bbt_select
    import bbt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_dec_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_item o_item
);

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;
    logic      any_err;
    logic      div_zero;

    always_comb begin
        any_err  = i_item.a_err || i_item.b_err;
        div_zero = (i_item.vb == '0);

        n_item.code   = ERR_CODE;
        n_item.is_div = 1'b0;
        n_item.is_mod = (i_item.cmd == CMD_MOD);
        n_item.neg_q  = i_item.va[16] ^ i_item.vb[16];
        n_item.neg_r  = i_item.va[16];
        n_item.num    = i_item.va[16] ? WORD_W'(-i_item.va) : WORD_W'(i_item.va);
        n_item.den    = i_item.vb[16] ? WORD_W'(-i_item.vb) : WORD_W'(i_item.vb);
        n_item.rem    = '0;

        case (i_item.cmd)
            CMD_ADD: begin
                if (!any_err) begin
                    n_item.code = enc_checked(34'(i_item.sum));
                end
            end
            CMD_SUB: begin
                if (!any_err) begin
                    n_item.code = enc_checked(34'(i_item.diff));
                end
            end
            CMD_MUL: begin
                if (!any_err) begin
                    n_item.code = enc_checked(i_item.prod);
                end
            end
            CMD_DIV, CMD_MOD: begin
                n_item.is_div = !any_err && !div_zero;
            end
            CMD_NEG: begin
                if (!i_item.a_err) begin
                    n_item.code = i_item.neg_code;
                end
            end
            CMD_ABS: begin
                if (!i_item.a_err) begin
                    n_item.code = i_item.abs_code;
                end
            end
            default: begin
                n_item.code = ERR_CODE;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_item <= n_item;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // A division never enters the divider with a zero divisor.
    a_div_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.is_div |-> r_item.den != '0 && r_item.code == ERR_CODE)
        else $error("divide item with zero divisor or stale code");

endmodule

@@ rtl/bbt_div_step.sv @@
`timescale 1ns / 1ps

module bbt_div_step
    import bbt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_item o_item
);

    logic              r_valid;
    t_div_item         r_item;
    t_div_item         n_item;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   sub;

    // Restoring division: shift in the next dividend bit, keep the
    // difference when the divisor fits.
    always_comb begin
        n_item = i_item;
        trial  = '0;
        sub    = '0;
        for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            trial = {n_item.rem, n_item.num[WORD_W-1]};
            sub   = trial - {1'b0, n_item.den};
            if (!sub[WORD_W]) begin
                n_item.rem = sub[WORD_W-1:0];
                n_item.num = {n_item.num[WORD_W-2:0], 1'b1};
            end else begin
                n_item.rem = trial[WORD_W-1:0];
                n_item.num = {n_item.num[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_item <= n_item;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // The partial remainder stays below the divisor after every step.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.is_div |-> r_item.rem < r_item.den)
        else $error("partial remainder not below divisor");

endmodule

@@ rtl/bbt_finish.sv @@
`timescale 1ns / 1ps

module bbt_finish
    import bbt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_div_item         i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_result,
    output logic              o_error_flag
);

    logic              r_valid;
    logic [WORD_W-1:0] r_result;
    logic              r_error_flag;
    logic [WORD_W-1:0] n_result;
    logic [WORD_W-1:0] mag;
    logic              neg;

    // Quotient or remainder comes out as a magnitude; sign and range are
    // applied here before the biased encoding.
    always_comb begin
        mag = i_item.is_mod ? i_item.rem : i_item.num;
        neg = i_item.is_mod ? i_item.neg_r : i_item.neg_q;
        if (!i_item.is_div) begin
            n_result = i_item.code;
        end else if (mag > BIAS_W) begin
            n_result = ERR_CODE;
        end else if (neg) begin
            n_result = BIAS_W - mag;
        end else begin
            n_result = BIAS_W + mag;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_result     <= n_result;
                r_error_flag <= (n_result == ERR_CODE);
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_result     = r_result;
    assign o_error_flag = r_error_flag;

endmodule

@@ rtl/biased_balanced_ternary_alu_top.sv @@
`timescale 1ns / 1ps

// Arithmetic unit for 16-bit words that hold a balanced ternary value in
// biased form (stored = value + 29524 for ten trits; 0xFFFF is the error
// sentinel). Each request carries a command (add, subtract, multiply,
// truncating divide, truncating remainder, negate, absolute value) and two
// operands, and produces exactly one result with an error flag that is set
// whenever the result is the sentinel. The unit is a fully pipelined
// datapath of eleven register stages: operand decode with the multiplier,
// result selection with range checks, eight radix-4 restoring divider
// stages, and a final stage that signs, checks and encodes the divider
// output and serves as the output register. A new request can be accepted
// in every cycle while the output side does not stall. Each stage has its
// own valid bit and holds its item while the stage after it is full and
// stalled, so bubbles are squeezed out and the input keeps accepting
// requests while a finished result waits to be taken, until all stages are
// full. There is no state to configure and reset only clears the valid bits.

module biased_balanced_ternary_alu_top
    import bbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] cmd, [18:3] operand_a, [34:19] operand_b, [39:35] zero
    input  logic [39:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] result
    output logic [15:0] m_axis_tdata,
    // [0] error_flag
    output logic        m_axis_tuser
);

    logic      dec_valid;
    logic      dec_ready;
    t_dec_item dec_item;

    logic      div_valid [DIV_STAGES+1];
    logic      div_ready [DIV_STAGES+1];
    t_div_item div_item  [DIV_STAGES+1];

    // Stage 1: decode operands, add, subtract, multiply, negate, abs.
    bbt_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tdata[2:0]),
        .i_operand_a (s_axis_tdata[18:3]),
        .i_operand_b (s_axis_tdata[34:19]),
        .o_valid     (dec_valid),
        .i_ready     (dec_ready),
        .o_item      (dec_item)
    );

    // Stage 2: range checks, error handling and divider setup.
    bbt_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_item  (dec_item),
        .o_valid (div_valid[0]),
        .i_ready (div_ready[0]),
        .o_item  (div_item[0])
    );

    // Divider stages, two quotient bits each. Items that do not divide
    // simply ride along with their result already settled.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        bbt_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .o_ready (div_ready[g]),
            .i_item  (div_item[g]),
            .o_valid (div_valid[g+1]),
            .i_ready (div_ready[g+1]),
            .o_item  (div_item[g+1])
        );
    end

    // Final stage and output register.
    bbt_finish u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (div_valid[DIV_STAGES]),
        .o_ready      (div_ready[DIV_STAGES]),
        .i_item       (div_item[DIV_STAGES]),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (m_axis_tdata),
        .o_error_flag (m_axis_tuser)
    );

    // Reset empties the pipeline, so no result appears right after it.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // With the output register empty, every stage can move, so the input
    // side must be ready.
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

endmodule

@@ sim/tb_biased_balanced_ternary_alu_top.sv @@
`timescale 1ns / 1ps

module tb_biased_balanced_ternary_alu_top;

    import bbt_pkg::*;

    // Command code that the enum leaves unused; the block must answer it with an error.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Handy biased codes.
    localparam logic [15:0] MIN_CODE  = 16'd0;
    localparam logic [15:0] ZERO_CODE = 16'(BIAS);
    localparam logic [15:0] ONE_CODE  = 16'(BIAS + 1);
    localparam logic [15:0] MONE_CODE = 16'(BIAS - 1);
    localparam logic [15:0] MAX_CODE  = 16'(2 * BIAS);
    localparam logic [15:0] TOP_CODE  = 16'hFFFE;

    localparam int PIPE_DEPTH     = 11;
    localparam int DRAIN_CYCLES   = 4 * PIPE_DEPTH;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1025;
    localparam int CALM_ITEMS     = 150;

    localparam logic KNOWN = 1'b1;
    localparam logic MODEL = 1'b0;

    typedef struct packed {
        logic [15:0] code;
        logic        err;
    } t_alu_result;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic        known;
        logic [15:0] code;
    } t_vec;

    localparam int DIR_COUNT = 25;

    // Directed cases. Rows marked KNOWN carry the answer; MODEL rows go through the predictor.
    localparam t_vec DIRECTED [0:DIR_COUNT-1] = '{
        '{CMD_ADD,    ZERO_CODE,        ZERO_CODE,       KNOWN, ZERO_CODE},
        '{CMD_ADD,    MAX_CODE,         ONE_CODE,        KNOWN, ERR_CODE},
        '{CMD_ADD,    MIN_CODE,         MAX_CODE,        KNOWN, ZERO_CODE},
        '{CMD_ADD,    ERR_CODE,         ZERO_CODE,       KNOWN, ERR_CODE},
        '{CMD_SUB,    MIN_CODE,         ONE_CODE,        KNOWN, ERR_CODE},
        '{CMD_SUB,    ZERO_CODE,        ERR_CODE,        KNOWN, ERR_CODE},
        '{CMD_MUL,    MAX_CODE,         ONE_CODE,        KNOWN, MAX_CODE},
        '{CMD_MUL,    MAX_CODE,         MAX_CODE,        KNOWN, ERR_CODE},
        '{CMD_MUL,    MIN_CODE,         MONE_CODE,       KNOWN, MAX_CODE},
        '{CMD_MUL,    TOP_CODE,         TOP_CODE,        MODEL, '0},
        '{CMD_DIV,    MAX_CODE,         ZERO_CODE,       KNOWN, ERR_CODE},
        '{CMD_MOD,    MIN_CODE,         ZERO_CODE,       KNOWN, ERR_CODE},
        '{CMD_DIV,    MIN_CODE,         MONE_CODE,       KNOWN, MAX_CODE},
        '{CMD_DIV,    16'(BIAS - 7),    16'(BIAS + 2),   MODEL, '0},
        '{CMD_MOD,    16'(BIAS - 7),    16'(BIAS + 2),   MODEL, '0},
        '{CMD_MOD,    16'(BIAS + 7),    16'(BIAS - 2),   MODEL, '0},
        '{CMD_DIV,    TOP_CODE,         ONE_CODE,        KNOWN, ERR_CODE},
        '{CMD_DIV,    TOP_CODE,         16'(BIAS + 2),   MODEL, '0},
        '{CMD_NEG,    MIN_CODE,         16'h5A5A,        KNOWN, MAX_CODE},
        '{CMD_NEG,    MAX_CODE,         ERR_CODE,        KNOWN, MIN_CODE},
        '{CMD_NEG,    16'(2 * BIAS + 1), ZERO_CODE,      KNOWN, ERR_CODE},
        '{CMD_NEG,    TOP_CODE,         16'hA5A5,        MODEL, '0},
        '{CMD_ABS,    MIN_CODE,         ERR_CODE,        KNOWN, MAX_CODE},
        '{CMD_ABS,    TOP_CODE,         ZERO_CODE,       KNOWN, TOP_CODE},
        '{CMD_UNUSED, ZERO_CODE,        ZERO_CODE,       KNOWN, ERR_CODE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [2:0] cmd, [18:3] operand_a, [34:19] operand_b, [39:35] zero
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] result
    logic [15:0] m_axis_tdata;
    // [0] error_flag
    logic        m_axis_tuser;

    // The request on the bus, when it has its answer typed in the table.
    logic        row_known = 1'b0;
    logic [15:0] row_code = '0;
    bit          calm_tail = 1'b0;

    t_alu_result results_q [$];
    int          fault_count = 0;
    int          request_count = 0;
    int          result_count = 0;
    int          err_result_count = 0;
    int          idle_cycles = 0;
    int          op_seen [8] = '{default: 0};

    biased_balanced_ternary_alu_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Exact balanced arithmetic and re-encoding; range check only for two-operand ops.
    function automatic t_alu_result compute_alu(input logic [2:0] op, input logic [15:0] a,
                                                input logic [15:0] b);
        longint      va;
        longint      vb;
        longint      exact;
        t_alu_result r;
        va = longint'(a) - BIAS;
        vb = longint'(b) - BIAS;
        exact = 0;
        r.code = ERR_CODE;
        case (op)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                if (a != ERR_CODE && b != ERR_CODE &&
                    !((op == CMD_DIV || op == CMD_MOD) && vb == 0)) begin
                    case (op)
                        CMD_ADD: exact = va + vb;
                        CMD_SUB: exact = va - vb;
                        CMD_MUL: exact = va * vb;
                        CMD_DIV: exact = va / vb;
                        default: exact = va % vb;
                    endcase
                    if (exact >= -BIAS && exact <= BIAS) begin
                        r.code = 16'(exact + BIAS);
                    end
                end
            end
            CMD_NEG: begin
                if (a != ERR_CODE) begin
                    r.code = 16'(2 * longint'(BIAS) - longint'(a));
                end
            end
            CMD_ABS: begin
                if (a != ERR_CODE) begin
                    r.code = 16'(((va < 0) ? -va : va) + BIAS);
                end
            end
            default: ;
        endcase
        r.err = (r.code == ERR_CODE);
        return r;
    endfunction

    // Operands lean toward small magnitudes so that products and quotients often stay in range.
    function automatic logic [15:0] pick_operand(input bit for_divisor);
        int unsigned sel;
        logic [15:0] v;
        sel = $urandom_range(0, 99);
        if (for_divisor && sel < 8) begin
            v = ZERO_CODE;
        end else if (sel < 35) begin
            v = 16'($urandom_range(0, 2 * BIAS));
        end else if (sel < 70) begin
            v = 16'($urandom_range(BIAS - 170, BIAS + 170));
        end else if (sel < 80) begin
            v = 16'($urandom);
        end else if (sel < 88) begin
            v = 16'($urandom_range(2 * BIAS + 1, 16'hFFFE));
        end else if (sel < 93) begin
            v = ERR_CODE;
        end else begin
            v = sel[0] ? MAX_CODE : MIN_CODE;
        end
        return v;
    endfunction

    // Sends one request, sometimes after a random gap, and returns once it is accepted.
    task automatic send_request(input logic [2:0] op, input logic [15:0] a, input logic [15:0] b,
                                input logic known, input logic [15:0] code);
        int unsigned gap;
        gap = $urandom_range(1, 11);
        @(negedge i_clk);
        if (!calm_tail && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, b, a, op};
        row_known = known;
        row_code  = code;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [2:0] op;
        logic [15:0] a;
        logic [15:0] b;
        wait (i_rst_n === 1'b1);
        for (int i = 0; i < DIR_COUNT; i++) begin
            send_request(DIRECTED[i].op, DIRECTED[i].a, DIRECTED[i].b,
                         DIRECTED[i].known, DIRECTED[i].code);
        end
        wait_for_drain();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Halfway through, hold the input until the pipeline is empty.
            if (n == RANDOM_ITEMS / 2) begin
                wait_for_drain();
            end
            calm_tail = (n >= RANDOM_ITEMS - CALM_ITEMS);
            op = ($urandom_range(0, 31) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 6));
            a  = pick_operand(1'b0);
            b  = pick_operand(op == CMD_DIV || op == CMD_MOD);
            send_request(op, a, b, MODEL, '0);
        end
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests (%0d directed) and %0d results, %0d of them errors.",
                 request_count, DIR_COUNT, result_count, err_result_count);
        $display("Requests per command code 0 to 7: %0d %0d %0d %0d %0d %0d %0d %0d.",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3],
                 op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Output side: stalls come in bursts, and stop for the calm tail of the run.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (calm_tail) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 11) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Records what each accepted request must produce and checks results in order.
    always @(posedge i_clk) begin : scoreboard
        t_alu_result want;
        logic [2:0]  op;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                op = s_axis_tdata[2:0];
                if (row_known) begin
                    want.code = row_code;
                    want.err  = (row_code == ERR_CODE);
                end else begin
                    want = compute_alu(op, s_axis_tdata[18:3], s_axis_tdata[34:19]);
                end
                results_q.push_back(want);
                request_count++;
                op_seen[op]++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (m_axis_tuser === 1'b1) begin
                    err_result_count++;
                end
                if (results_q.size() == 0) begin
                    $error("result %h arrived with no request outstanding", m_axis_tdata);
                    fault_count++;
                end else begin
                    want = results_q.pop_front();
                    if (m_axis_tdata !== want.code) begin
                        $error("result: expected %h, actual %h", want.code, m_axis_tdata);
                        fault_count++;
                    end
                    if (m_axis_tuser !== want.err) begin
                        $error("error_flag: expected %b, actual %b", want.err, m_axis_tuser);
                        fault_count++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $error("no handshake for %0d cycles, %0d results outstanding",
                           idle_cycles, results_q.size());
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

endmodule
